/* rtl/spc_pkg.sv */
// Shared constants for the sieve prime counter.
package spc_pkg;

  // Default size of the sieve bit map (entries 0..N_MAX)
  localparam int unsigned N_MAX_DEF = 65536;

  // Field widths on the stream ports
  localparam int unsigned LIMIT_W   = 17;
  localparam int unsigned COUNT_W   = 17;
  localparam int unsigned TDATA_W   = 24;

  // Sieve starting point: first odd base, its square, and the square increment
  localparam int unsigned FIRST_BASE = 3;
  localparam int unsigned FIRST_SQ   = 9;
  localparam int unsigned FIRST_INC  = 16;
  localparam int unsigned INC_STEP   = 8;
  localparam int unsigned FIRST_PRIME = 2;

endpackage

/* rtl/spc_alu.sv */
// Shared add-and-compare unit used for squares, increments and multiples.
module spc_alu #(
  parameter int unsigned W     = 18,
  parameter int unsigned IDX_W = 17
) (
  input  logic [W-1:0]     op_a_i,
  input  logic [W-1:0]     op_b_i,
  input  logic [IDX_W-1:0] bound_i,
  output logic [W-1:0]     sum_o,
  output logic             le_o
);

  // Add operands and check the sum against the limit
  assign sum_o = op_a_i + op_b_i;
  assign le_o  = (sum_o <= W'(bound_i));

endmodule

/* rtl/spc_map.sv */
// One-bit sieve map memory with one write port and one registered read port.
module spc_map #(
  parameter int unsigned DEPTH = 65537,
  parameter int unsigned AW    = 17
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic          wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic          rdata_o
);

  logic mem_q [DEPTH];

  // Write one bit
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read one bit, registered
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/spc_seq.sv */
// Sequencer for init, sieve and count passes over the bit map.
module spc_seq #(
  parameter int unsigned N_MAX = spc_pkg::N_MAX_DEF,
  parameter int unsigned IDX_W = $clog2(N_MAX + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [spc_pkg::LIMIT_W-1:0] limit_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  output logic [spc_pkg::COUNT_W-1:0] count_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        map_we_o,
  output logic [IDX_W-1:0]            map_waddr_o,
  output logic                        map_wdata_o,
  output logic [IDX_W-1:0]            map_raddr_o,
  input  logic                        map_rdata_i
);

  localparam int unsigned W       = IDX_W + 1;
  localparam int unsigned LIMIT_W = spc_pkg::LIMIT_W;
  localparam int unsigned COUNT_W = spc_pkg::COUNT_W;
  localparam int unsigned LW      = (W > LIMIT_W) ? W : LIMIT_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_BTEST,
    S_BCHK,
    S_STRIKE,
    S_BNEXT,
    S_BINC,
    S_CRUN,
    S_CTAIL,
    S_COUT
  } state_e;

  state_e               state_q, state_d;
  logic [IDX_W-1:0]     n_q, n_d;
  logic [W-1:0]         idx_q, idx_d;
  logic [W-1:0]         base_q, base_d;
  logic [W-1:0]         sq_q, sq_d;
  logic [W-1:0]         inc_q, inc_d;
  logic [W-1:0]         stride_q, stride_d;
  logic [IDX_W-1:0]     cnt_q, cnt_d;
  logic                 pend_q, pend_d;
  logic [COUNT_W-1:0]   out_q, out_d;
  logic                 out_valid_q, out_valid_d;

  logic [LW-1:0]        lim_ext;
  logic [LW-1:0]        lim_clamp;
  logic [W-1:0]         alu_a, alu_b, alu_sum;
  logic                 alu_le;
  logic                 at_end;

  // Clamp the requested limit to the map size
  assign lim_ext   = LW'(limit_i);
  assign lim_clamp = (lim_ext > LW'(N_MAX)) ? LW'(N_MAX) : lim_ext;
  assign at_end    = (idx_q == W'(n_q));

  // Pick operands for the shared unit
  always_comb begin
    unique case (state_q)
      S_BTEST: begin
        alu_a = sq_q;
        alu_b = '0;
      end
      S_STRIKE: begin
        alu_a = idx_q;
        alu_b = stride_q;
      end
      S_BNEXT: begin
        alu_a = sq_q;
        alu_b = inc_q;
      end
      S_BINC: begin
        alu_a = inc_q;
        alu_b = W'(spc_pkg::INC_STEP);
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  spc_alu #(
    .W     (W),
    .IDX_W (IDX_W)
  ) u_alu (
    .op_a_i  (alu_a),
    .op_b_i  (alu_b),
    .bound_i (n_q),
    .sum_o   (alu_sum),
    .le_o    (alu_le)
  );

  // Drive the map ports
  always_comb begin
    map_we_o    = 1'b0;
    map_wdata_o = 1'b0;
    map_waddr_o = idx_q[IDX_W-1:0];
    map_raddr_o = idx_q[IDX_W-1:0];
    unique case (state_q)
      S_INIT: begin
        map_we_o    = 1'b1;
        map_wdata_o = idx_q[0] || (idx_q == W'(spc_pkg::FIRST_PRIME));
      end
      S_STRIKE: begin
        map_we_o = 1'b1;
      end
      S_BTEST: begin
        map_raddr_o = base_q[IDX_W-1:0];
      end
      default: begin
        map_we_o = 1'b0;
      end
    endcase
  end

  // Next-state and datapath
  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    idx_d       = idx_q;
    base_d      = base_q;
    sq_d        = sq_q;
    inc_d       = inc_q;
    stride_d    = stride_q;
    cnt_d       = cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    pend_d      = (state_q == S_CRUN);

    // Retire the output word once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    // Accumulate marked entries arriving from the read port
    if (pend_q && map_rdata_i) begin
      cnt_d = cnt_q + IDX_W'(1);
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          n_d    = IDX_W'(lim_clamp);
          idx_d  = W'(spc_pkg::FIRST_PRIME);
          base_d = W'(spc_pkg::FIRST_BASE);
          sq_d   = W'(spc_pkg::FIRST_SQ);
          inc_d  = W'(spc_pkg::FIRST_INC);
          cnt_d  = '0;
          if (lim_clamp < LW'(spc_pkg::FIRST_PRIME)) begin
            state_d = S_COUT;
          end else begin
            state_d = S_INIT;
          end
        end
      end
      S_INIT: begin
        if (at_end) begin
          state_d = S_BTEST;
        end else begin
          idx_d = idx_q + W'(1);
        end
      end
      S_BTEST: begin
        if (alu_le) begin
          state_d = S_BCHK;
        end else begin
          idx_d   = W'(spc_pkg::FIRST_PRIME);
          state_d = S_CRUN;
        end
      end
      S_BCHK: begin
        if (map_rdata_i) begin
          idx_d    = sq_q;
          stride_d = base_q << 1;
          state_d  = S_STRIKE;
        end else begin
          state_d = S_BNEXT;
        end
      end
      S_STRIKE: begin
        if (alu_le) begin
          idx_d = alu_sum;
        end else begin
          state_d = S_BNEXT;
        end
      end
      S_BNEXT: begin
        sq_d    = alu_sum;
        base_d  = base_q + W'(2);
        state_d = S_BINC;
      end
      S_BINC: begin
        inc_d   = alu_sum;
        state_d = S_BTEST;
      end
      S_CRUN: begin
        if (at_end) begin
          state_d = S_CTAIL;
        end else begin
          idx_d = idx_q + W'(1);
        end
      end
      S_CTAIL: begin
        state_d = S_COUT;
      end
      S_COUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = COUNT_W'(cnt_q);
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      base_q      <= '0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      base_q      <= base_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    idx_q    <= idx_d;
    sq_q     <= sq_d;
    inc_q    <= inc_d;
    stride_q <= stride_d;
    out_q    <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign count_o     = out_q;

endmodule

/* rtl/sieve_prime_counter.sv */
// A clamped limit n >= 2 runs an init pass over entries 2..n, then a sieve pass over the odd
// bases b >= 3 with b*b <= n that clears the odd multiples of each marked base from its square,
// then a count pass over entries 2..n.
// A limit below two skips the passes and returns a count of zero. One word at a time: the bit map
// has one write and one read port, and the init, sieve and count passes all go through it.
// Reset clears the sequencer and output valid; the bit map is not cleared (every request rewrites what it reads).
module sieve_prime_counter #(
  parameter int unsigned N_MAX = spc_pkg::N_MAX_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [spc_pkg::TDATA_W-1:0] s_axis_tdata,  // [16:0] limit
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [spc_pkg::TDATA_W-1:0] m_axis_tdata   // [16:0] prime_count
);

  localparam int unsigned IDX_W = $clog2(N_MAX + 1);

  logic                        map_we;
  logic [IDX_W-1:0]            map_waddr;
  logic                        map_wdata;
  logic [IDX_W-1:0]            map_raddr;
  logic                        map_rdata;
  logic [spc_pkg::COUNT_W-1:0] count;

  spc_seq #(
    .N_MAX (N_MAX),
    .IDX_W (IDX_W)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .limit_i     (s_axis_tdata[spc_pkg::LIMIT_W-1:0]),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .count_o     (count),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .map_we_o    (map_we),
    .map_waddr_o (map_waddr),
    .map_wdata_o (map_wdata),
    .map_raddr_o (map_raddr),
    .map_rdata_i (map_rdata)
  );

  spc_map #(
    .DEPTH (N_MAX + 1),
    .AW    (IDX_W)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  // Pad the count to whole bytes
  assign m_axis_tdata = spc_pkg::TDATA_W'(count);

endmodule

/* rtl/spc_checker.sv */
// Port-level checks for the sieve prime counter, bound to the top level.
module spc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [spc_pkg::TDATA_W-1:0] m_axis_tdata
);

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // Block is busy right after taking a word
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("ready high right after input accept");

  // No result can appear in the cycle right after an accept
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(m_axis_tvalid))
    else $error("result appeared one cycle after accept");

  // Stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // Pad bits above the count stay zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[spc_pkg::TDATA_W-1:spc_pkg::COUNT_W] == '0))
    else $error("output pad bits nonzero");

endmodule

bind sieve_prime_counter spc_checker u_spc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* dv/tb.sv */
// Self-checking testbench for the sieve prime counter: stream stimulus, prime-count prediction and checks.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned TDATA_W     = spc_pkg::TDATA_W;
  localparam int unsigned LIMIT_W     = spc_pkg::LIMIT_W;
  localparam int unsigned COUNT_W     = spc_pkg::COUNT_W;
  localparam int unsigned FIRST_PRIME = spc_pkg::FIRST_PRIME;
  localparam int unsigned FIRST_BASE  = spc_pkg::FIRST_BASE;

  localparam int unsigned SIEVE_N    = spc_pkg::N_MAX_DEF;
  localparam int unsigned HOLD_AT    = 25;    // result after which the receiver backs off
  localparam int unsigned LONG_HOLD  = 1500;  // cycles the receiver holds off
  localparam int unsigned DRAIN_AT   = 50;    // limit that waits for all counts first
  localparam int unsigned TAIL_ITEMS = 12;    // final limits sent without idling
  localparam int unsigned SETTLE     = 64;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [TDATA_W-1:0]   s_axis_tdata  = '0;  // [16:0] limit
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]   m_axis_tdata;        // [16:0] prime_count

  logic [LIMIT_W-1:0]   pending_limits[$];
  logic [COUNT_W-1:0]   expected_counts[$];

  logic                 quiet_tail    = 1'b0;
  int unsigned          limits_sent   = 0;
  int unsigned          counts_seen   = 0;
  int unsigned          fail_cnt      = 0;
  int unsigned          clamped_cnt   = 0;
  int unsigned          trivial_cnt   = 0;
  longint unsigned      work_budget   = 0;
  longint unsigned      cycle_cnt     = 0;
  longint unsigned      cycle_limit   = 64'd1 << 40;

  sieve_prime_counter #(
    .N_MAX(SIEVE_N)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Run the clock at 12 ns
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Hold reset at the start, then release it
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Count the primes in 2..limit with a bit-map sieve, limit clamped to the map size
  function automatic logic [COUNT_W-1:0] count_primes(input logic [LIMIT_W-1:0] limit);
    bit          marked [0:SIEVE_N];
    int unsigned n;
    int unsigned i;
    int unsigned b;
    int unsigned m;
    int unsigned total;
    n     = (limit > SIEVE_N) ? SIEVE_N : int'(limit);
    total = 0;
    if (n >= FIRST_PRIME) begin
      for (i = FIRST_PRIME; i <= n; i++) marked[i] = 1'b1;
      for (i = 2 * FIRST_PRIME; i <= n; i += 2) marked[i] = 1'b0;
      // strike odd multiples of each surviving odd base, starting at its square
      for (b = FIRST_BASE; longint'(b) * b <= n; b += 2) begin
        if (marked[b]) begin
          for (m = b * b; m <= n; m += 2 * b) marked[m] = 1'b0;
        end
      end
      for (i = FIRST_PRIME; i <= n; i++) total += marked[i];
    end
    return COUNT_W'(total);
  endfunction

  // Queue one limit and grow the cycle budget by its worst-case cost
  task automatic queue_limit(input logic [LIMIT_W-1:0] lim);
    longint unsigned n;
    n = (lim > SIEVE_N) ? SIEVE_N : lim;
    pending_limits.push_back(lim);
    work_budget += 4 * n + 250;
    if (lim > SIEVE_N) clamped_cnt++;
    if (lim < FIRST_PRIME) trivial_cnt++;
  endtask

  // Fill the limit queue, then wait for every count and report
  initial begin : stimulus
    int unsigned pick;
    // zero and one, the smallest primes, limits on and just below a square bound
    queue_limit(17'd0);
    queue_limit(17'd1);
    queue_limit(17'd2);
    queue_limit(17'd3);
    queue_limit(17'd4);
    queue_limit(17'd5);
    queue_limit(17'd8);
    queue_limit(17'd9);
    queue_limit(17'd24);
    queue_limit(17'd25);
    queue_limit(17'd48);
    queue_limit(17'd49);
    queue_limit(17'd120);
    queue_limit(17'd121);
    queue_limit(17'd1023);
    // the full map, then all ones which clamps to it
    queue_limit(LIMIT_W'(SIEVE_N));
    queue_limit(17'h1FFFF);
    // mostly small limits, a few mid-sized ones
    repeat (83) begin
      pick = $urandom_range(0, 99);
      if (pick < 5)       queue_limit(LIMIT_W'($urandom_range(0, 1)));
      else if (pick < 80) queue_limit(LIMIT_W'($urandom_range(2, 400)));
      else if (pick < 95) queue_limit(LIMIT_W'($urandom_range(401, 3000)));
      else                queue_limit(LIMIT_W'($urandom_range(3001, 12000)));
    end
    cycle_limit = 4 * (work_budget + LONG_HOLD + 60 * pending_limits.size()) + 50000;

    do @(posedge clk_i);
    while (pending_limits.size() != 0 || expected_counts.size() != 0);
    repeat (SETTLE) @(posedge clk_i);

    $display("[tb] %0d limits sent (%0d below two, %0d clamped to the map size)",
             limits_sent, trivial_cnt, clamped_cnt);
    $display("[tb] %0d prime counts checked in %0d cycles, %0d failures",
             counts_seen, cycle_cnt, fail_cnt);
    if (fail_cnt == 0) begin
      $display("[sieve_prime_counter] OK");
    end else begin
      $display("[sieve_prime_counter] ERROR");
    end
    $finish;
  end

  // Drive limit words; idle in random bursts and wait for a full drain once
  always @(posedge clk_i or negedge rst_ni) begin : drive_limits
    int unsigned        send_gap;
    logic               next_valid;
    logic [TDATA_W-1:0] next_data;
    if (!rst_ni) begin
      send_gap = 0;
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      next_data = s_axis_tdata;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_counts.push_back(count_primes(pending_limits[0]));
        pending_limits.delete(0);
        limits_sent++;
      end
      next_valid = s_axis_tvalid && !s_axis_tready;
      if (!next_valid) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (pending_limits.size() != 0) begin
          if (limits_sent == DRAIN_AT && expected_counts.size() != 0) begin
            // hold until every count is back
          end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(1, 19) - 1;
          end else begin
            next_valid = 1'b1;
            next_data  = TDATA_W'(pending_limits[0]);
          end
        end
      end
      quiet_tail    <= (pending_limits.size() <= TAIL_ITEMS);
      s_axis_tvalid <= next_valid;
      s_axis_tdata  <= next_data;
    end
  end

  // Check each count word against the oldest prediction; stall in bursts
  always @(posedge clk_i or negedge rst_ni) begin : check_counts
    int unsigned        stall_left;
    int unsigned        hold_left;
    logic [COUNT_W-1:0] got;
    logic [COUNT_W-1:0] want;
    logic               next_ready;
    if (!rst_ni) begin
      stall_left = 0;
      hold_left  = 0;
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[COUNT_W-1:0];
        counts_seen++;
        if (expected_counts.size() == 0) begin
          $error("prime_count: none expected, actual %0d", got);
          fail_cnt++;
        end else begin
          want = expected_counts.pop_front();
          if (got !== want) begin
            $error("prime_count: expected %0d, actual %0d", want, got);
            fail_cnt++;
          end
        end
        // back off long enough for the block to fill and stall its input
        if (counts_seen == HOLD_AT) hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        next_ready = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      m_axis_tready <= next_ready;
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > cycle_limit) begin
      $display("[tb] timeout after %0d cycles, %0d counts outstanding",
               cycle_cnt, expected_counts.size());
      $display("[sieve_prime_counter] ERROR");
      $finish;
    end
  end

endmodule
